// ----- sv/trrs_pkg.sv -----
// Shared types, codes and ready-ring helpers for the two-level round-robin scheduler.
package trrs_pkg;

  localparam int NPROC = 16;
  localparam int PID_W = 4;
  localparam int CNT_W = 5;

  typedef logic [PID_W-1:0] pid_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [NPROC-1:0][PID_W-1:0] ring_t;

  typedef struct packed {
    ring_t ring;
    cnt_t  cnt;
  } ring_op_t;

  typedef enum logic [2:0] {
    OP_SCHED  = 3'd0,
    OP_SETPRI = 3'd1,
    OP_BLOCK  = 3'd2,
    OP_EMIT   = 3'd3,
    OP_EXIT   = 3'd4,
    OP_KILL   = 3'd5,
    OP_FORK   = 3'd6,
    OP_NOP    = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    PS_FREE    = 3'd0,
    PS_RUN     = 3'd1,
    PS_READY   = 3'd2,
    PS_BLOCKED = 3'd3,
    PS_TERM    = 3'd4
  } pstate_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NONE_RUN  = 3'd1;
  localparam logic [2:0] ST_LAST_PROC = 3'd2;
  localparam logic [2:0] ST_TAB_FULL  = 3'd3;
  localparam logic [2:0] ST_NO_CUR    = 3'd4;

  localparam logic [2:0] EV_CREATED = 3'd0;
  localparam logic [2:0] EV_EXITED  = 3'd1;
  localparam logic [2:0] EV_BLOCKED = 3'd2;

  localparam logic LVL_HIGH = 1'b0;
  localparam logic LVL_LOW  = 1'b1;

  typedef struct packed {
    logic [2:0] req_type;
    logic [3:0] target_pid;
    logic       priority_level;
    logic [2:0] event_kind;
    logic [3:0] event_pid;
  } req_t;

  typedef struct packed {
    logic [3:0]  running_pid;
    logic [3:0]  result_pid;
    logic [2:0]  status;
    logic [15:0] woken_mask;
  } rsp_t;

  typedef struct packed {
    op_t        op;
    pid_t       target_pid;
    logic       priority_level;
    logic [2:0] event_kind;
    pid_t       event_pid;
  } cmd_t;

  function automatic ring_op_t ring_remove(ring_t r, cnt_t c, pid_t p);
    ring_op_t o;
    logic     hit;
    o.ring = r;
    o.cnt  = c;
    hit    = 1'b0;
    for (int j = 0; j < NPROC - 1; j++) begin
      if (CNT_W'(j) < c && r[j] == p) hit = 1'b1;
      if (hit) o.ring[j] = r[j+1];
    end
    if (c == CNT_W'(NPROC) && r[NPROC-1] == p) hit = 1'b1;
    if (hit) o.cnt = c - 1'b1;
    return o;
  endfunction

  function automatic ring_op_t ring_push(ring_t r, cnt_t c, pid_t p);
    ring_op_t o;
    o.ring = r;
    o.cnt  = c;
    if (c < CNT_W'(NPROC)) begin
      o.ring[c[PID_W-1:0]] = p;
      o.cnt = c + 1'b1;
    end
    return o;
  endfunction

  function automatic ring_op_t ring_rotate(ring_t r, cnt_t c);
    ring_op_t o;
    cnt_t     last;
    o.ring = r;
    o.cnt  = c;
    last   = c - 1'b1;
    for (int j = 0; j < NPROC - 1; j++) begin
      o.ring[j] = r[j+1];
    end
    if (c != '0) o.ring[last[PID_W-1:0]] = r[0];
    return o;
  endfunction

  function automatic logic others_queued(ring_t h, cnt_t hc, ring_t l, cnt_t lc, pid_t p);
    logic any;
    any = 1'b0;
    for (int j = 0; j < NPROC; j++) begin
      if (CNT_W'(j) < hc && h[j] != p) any = 1'b1;
      if (CNT_W'(j) < lc && l[j] != p) any = 1'b1;
    end
    return any;
  endfunction

endpackage

// ----- sv/trrs_front.sv -----
// Front part: accepts request items, classifies them and holds them in a two-entry queue.
module trrs_front
  import trrs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  req_t req,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);

  cmd_t       q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  cmd_t       cls;
  logic       do_wr;
  logic       do_rd;

  always_comb begin
    cls.target_pid     = req.target_pid;
    cls.priority_level = req.priority_level;
    cls.event_kind     = req.event_kind;
    cls.event_pid      = req.event_pid;
    cls.op             = op_t'(req.req_type);
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rptr];
  assign do_wr     = push && !full;
  assign do_rd     = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) q[wptr] <= cls;
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) wptr <= ~wptr;
      if (do_rd) rptr <= ~rptr;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/trrs_back.sv -----
// Back part: process table, ready rings and the sequencer that carries out each command.
module trrs_back
  import trrs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic empty,
  input  logic pop,
  output rsp_t rsp
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCHED = 4'b0010,
    S_EMIT  = 4'b0100,
    S_DONE  = 4'b1000
  } fsm_t;

  fsm_t       fsm;
  pstate_t    ps [NPROC];
  logic [2:0] wk [NPROC];
  pid_t       ws [NPROC];
  ring_t      hring;
  ring_t      lring;
  cnt_t       hcnt;
  cnt_t       lcnt;
  pid_t       cur;
  cnt_t       nfp;

  logic        sched_pend;
  logic        emit_pend;
  logic        term_flag;
  pid_t        term_pid;
  logic [2:0]  ev_kind;
  pid_t        ev_src;
  pid_t        e;
  logic [2:0]  st;
  pid_t        rpid;
  logic [15:0] mask;
  logic        res_valid;

  logic     mv_leave;
  logic     mv_push;
  logic     mv_lvl;
  pid_t     mv_pid;
  logic     rot;
  ring_op_t rm_h;
  ring_op_t rm_l;
  ring_op_t h_next;
  ring_op_t l_next;
  logic     others;
  logic     kill_ok;
  logic     is_cur;
  logic     emit_hit;
  pid_t     sched_pid;
  pid_t     child;

  assign cmd_ready = (fsm == S_IDLE);
  assign empty     = !res_valid;
  assign child     = nfp[PID_W-1:0];
  assign others    = others_queued(hring, hcnt, lring, lcnt, cur);
  assign kill_ok   = cmd.target_pid != '0 && ps[cmd.target_pid] != PS_FREE
                     && ps[cmd.target_pid] != PS_TERM;
  assign is_cur    = cur != '0 && cmd.target_pid == cur;
  assign emit_hit  = ps[e] == PS_BLOCKED && wk[e] == ev_kind && ws[e] == ev_src;
  assign sched_pid = (hcnt != '0) ? hring[0] : ((lcnt != '0) ? lring[0] : '0);

  always_comb begin
    mv_leave = 1'b0;
    mv_push  = 1'b0;
    mv_lvl   = LVL_LOW;
    mv_pid   = '0;
    rot      = 1'b0;
    case (fsm)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_SETPRI: begin
              if (cmd.target_pid != '0 && (ps[cmd.target_pid] == PS_READY
                  || ps[cmd.target_pid] == PS_RUN)) begin
                mv_leave = 1'b1;
                mv_push  = 1'b1;
                mv_lvl   = cmd.priority_level;
                mv_pid   = cmd.target_pid;
              end
            end
            OP_BLOCK: begin
              mv_leave = cur != '0;
              mv_pid   = cur;
            end
            OP_EXIT: begin
              mv_leave = cur != '0 && others;
              mv_pid   = cur;
            end
            OP_KILL: begin
              mv_leave = kill_ok && (!is_cur || others);
              mv_pid   = cmd.target_pid;
            end
            OP_FORK: begin
              mv_push = cur != '0 && !nfp[CNT_W-1];
              mv_pid  = child;
            end
            default: begin
              mv_leave = 1'b0;
            end
          endcase
        end
      end
      S_SCHED: rot = 1'b1;
      S_EMIT: begin
        mv_leave = emit_hit;
        mv_push  = emit_hit;
        mv_pid   = e;
      end
      default: rot = 1'b0;
    endcase
  end

  always_comb begin
    rm_h   = ring_remove(hring, hcnt, mv_pid);
    rm_l   = ring_remove(lring, lcnt, mv_pid);
    h_next = mv_leave ? rm_h : '{ring: hring, cnt: hcnt};
    l_next = mv_leave ? rm_l : '{ring: lring, cnt: lcnt};
    if (mv_push) begin
      if (mv_lvl == LVL_HIGH) h_next = ring_push(h_next.ring, h_next.cnt, mv_pid);
      else                    l_next = ring_push(l_next.ring, l_next.cnt, mv_pid);
    end
    if (rot) begin
      if (hcnt != '0)      h_next = ring_rotate(hring, hcnt);
      else if (lcnt != '0) l_next = ring_rotate(lring, lcnt);
    end
  end

  always_ff @(posedge clk) begin
    hring <= h_next.ring;
    if (rst) begin
      fsm       <= S_IDLE;
      res_valid <= 1'b0;
      for (int i = 0; i < NPROC; i++) begin
        ps[i] <= (i == 1) ? PS_RUN : PS_FREE;
        wk[i] <= '0;
        ws[i] <= '0;
      end
      lring      <= ring_t'(1);
      hcnt       <= '0;
      lcnt       <= CNT_W'(1);
      cur        <= PID_W'(1);
      nfp        <= CNT_W'(2);
      sched_pend <= 1'b0;
      emit_pend  <= 1'b0;
      term_flag  <= 1'b0;
    end else begin
      lring <= l_next.ring;
      hcnt  <= h_next.cnt;
      lcnt  <= l_next.cnt;
      if (pop && res_valid) res_valid <= 1'b0;
      case (fsm)
        S_IDLE: begin
          if (cmd_valid) begin
            st         <= ST_OK;
            rpid       <= '0;
            mask       <= '0;
            sched_pend <= 1'b0;
            emit_pend  <= 1'b0;
            term_flag  <= 1'b0;
            e          <= PID_W'(1);
            fsm        <= S_DONE;
            case (cmd.op)
              OP_SCHED: fsm <= S_SCHED;
              OP_BLOCK: begin
                if (cur == '0) begin
                  st <= ST_NO_CUR;
                end else begin
                  wk[cur]    <= cmd.event_kind;
                  ws[cur]    <= cmd.event_pid;
                  ps[cur]    <= PS_BLOCKED;
                  ev_kind    <= EV_BLOCKED;
                  ev_src     <= cur;
                  rpid       <= cmd.event_pid;
                  sched_pend <= 1'b1;
                  fsm        <= S_EMIT;
                end
              end
              OP_EMIT: begin
                ev_kind <= cmd.event_kind;
                ev_src  <= cmd.event_pid;
                fsm     <= S_EMIT;
              end
              OP_EXIT: begin
                if (cur == '0) begin
                  st <= ST_NO_CUR;
                end else if (!others) begin
                  st <= ST_LAST_PROC;
                end else begin
                  term_flag <= 1'b1;
                  term_pid  <= cur;
                  ev_kind   <= EV_EXITED;
                  ev_src    <= cur;
                  emit_pend <= 1'b1;
                  fsm       <= S_SCHED;
                end
              end
              OP_KILL: begin
                if (kill_ok) begin
                  if (is_cur) begin
                    if (!others) begin
                      st <= ST_LAST_PROC;
                    end else begin
                      term_flag <= 1'b1;
                      term_pid  <= cur;
                      ev_kind   <= EV_EXITED;
                      ev_src    <= cur;
                      emit_pend <= 1'b1;
                      fsm       <= S_SCHED;
                    end
                  end else begin
                    ps[cmd.target_pid] <= PS_TERM;
                    ev_kind   <= EV_EXITED;
                    ev_src    <= cmd.target_pid;
                    emit_pend <= 1'b1;
                    fsm       <= S_SCHED;
                  end
                end
              end
              OP_FORK: begin
                if (cur == '0) begin
                  st <= ST_NO_CUR;
                end else if (nfp[CNT_W-1]) begin
                  st <= ST_TAB_FULL;
                end else begin
                  ps[child] <= PS_READY;
                  wk[child] <= wk[cur];
                  ws[child] <= ws[cur];
                  nfp       <= nfp + 1'b1;
                  ev_kind   <= EV_CREATED;
                  ev_src    <= child;
                  rpid      <= child;
                  fsm       <= S_EMIT;
                end
              end
              default: fsm <= S_DONE;
            endcase
          end
        end
        S_SCHED: begin
          if (cur != '0 && ps[cur] == PS_RUN) ps[cur] <= PS_READY;
          if (sched_pid != '0) begin
            cur            <= sched_pid;
            ps[sched_pid]  <= PS_RUN;
          end else begin
            cur <= '0;
            st  <= ST_NONE_RUN;
          end
          if (term_flag) ps[term_pid] <= PS_TERM;
          fsm <= emit_pend ? S_EMIT : S_DONE;
        end
        S_EMIT: begin
          if (emit_hit) begin
            ps[e]   <= PS_READY;
            mask[e] <= 1'b1;
          end
          if (e == PID_W'(NPROC - 1)) fsm <= sched_pend ? S_SCHED : S_DONE;
          else                         e   <= e + 1'b1;
        end
        S_DONE: begin
          if (!res_valid || pop) begin
            rsp.running_pid <= cur;
            rsp.result_pid  <= rpid;
            rsp.status      <= st;
            rsp.woken_mask  <= mask;
            res_valid       <= 1'b1;
            fsm             <= S_IDLE;
          end
        end
        default: fsm <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/two_level_round_robin_scheduler.sv -----
// Top level of the two-level round-robin scheduler.
// Each request item gives one result item. A request enters a two-entry queue,
// is taken by the sequencer once it is idle and runs there alone: set priority
// and requests refused at once go straight to the result; schedule passes the
// scheduling state; emit and fork walk the process table one entry a cycle;
// block, exit and kill add the scheduling state to that walk. The result
// waits in an output register, so the next item starts while it is held.
module two_level_round_robin_scheduler
  import trrs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  req_t req,
  output logic empty,
  input  logic pop,
  output rsp_t rsp
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  trrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  trrs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .rsp       (rsp)
  );

endmodule

// ----- sv/trrs_checker.sv -----
// Port-level checks of the scheduler and their binding to the top level.
module trrs_props
  import trrs_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input req_t req,
  input logic empty,
  input logic pop,
  input rsp_t rsp
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(rsp))
    else $error("waiting result item changed before it was taken");

  a_status: assert property (@(posedge clk) disable iff (rst)
    !empty |-> rsp.status <= ST_NO_CUR)
    else $error("undefined status code");

  a_idle: assert property (@(posedge clk) disable iff (rst)
    !empty && rsp.status == ST_NONE_RUN |-> rsp.running_pid == '0)
    else $error("nothing runnable but a process is reported running");

  a_refused: assert property (@(posedge clk) disable iff (rst)
    !empty && (rsp.status == ST_NO_CUR || rsp.status == ST_TAB_FULL
      || rsp.status == ST_LAST_PROC) |-> rsp.woken_mask == '0)
    else $error("refused request woke processes");

  a_pid0: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !rsp.woken_mask[0])
    else $error("pid zero reported as woken");

endmodule

bind two_level_round_robin_scheduler trrs_props u_trrs_props (.*);

// ----- tb/trrs_checker.sv -----
// Checker for the scheduler: predicts each result item and compares it with the block.
module trrs_checker
  import trrs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic full,
  input  req_t req,
  input  logic empty,
  input  logic pop,
  input  rsp_t rsp,
  output int   errors,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  pstate_t    pstate[NPROC];
  logic [2:0] wkind[NPROC];
  pid_t       wsrc[NPROC];
  pid_t       hiq[$];
  pid_t       loq[$];
  int         cur_pid;
  int         fresh_pid;
  rsp_t       expected_rsp[$];

  function automatic bit valid_pid(int p);
    return p != 0 && p < NPROC;
  endfunction

  function automatic void drop_from_rings(int p);
    for (int i = hiq.size() - 1; i >= 0; i--) if (hiq[i] == p) hiq.delete(i);
    for (int i = loq.size() - 1; i >= 0; i--) if (loq[i] == p) loq.delete(i);
  endfunction

  function automatic void enqueue_at(int p, logic lvl);
    drop_from_rings(p);
    if (lvl == LVL_HIGH) begin
      if (hiq.size() < NPROC) hiq.push_back(pid_t'(p));
    end else begin
      if (loq.size() < NPROC) loq.push_back(pid_t'(p));
    end
  endfunction

  function automatic logic [2:0] pick_next();
    int p;
    p = 0;
    if (hiq.size() > 0) begin
      p = hiq.pop_front();
      hiq.push_back(pid_t'(p));
    end else if (loq.size() > 0) begin
      p = loq.pop_front();
      loq.push_back(pid_t'(p));
    end
    if (valid_pid(cur_pid) && pstate[cur_pid] == PS_RUN) pstate[cur_pid] = PS_READY;
    if (!valid_pid(p)) begin
      cur_pid = 0;
      return ST_NONE_RUN;
    end
    cur_pid = p;
    pstate[p] = PS_RUN;
    return ST_OK;
  endfunction

  function automatic logic [15:0] wake_waiters(logic [2:0] kind, int src);
    logic [15:0] m;
    m = '0;
    for (int p = 1; p < NPROC; p++) begin
      if (pstate[p] == PS_BLOCKED && wkind[p] == kind && wsrc[p] == src) begin
        pstate[p] = PS_READY;
        enqueue_at(p, LVL_LOW);
        m[p] = 1'b1;
      end
    end
    return m;
  endfunction

  function automatic logic [2:0] retire_running(inout logic [15:0] m);
    int         p;
    bit         others;
    logic [2:0] st;
    p = cur_pid;
    others = 0;
    foreach (hiq[i]) if (hiq[i] != p) others = 1;
    foreach (loq[i]) if (loq[i] != p) others = 1;
    if (!others) return ST_LAST_PROC;
    drop_from_rings(p);
    st = pick_next();
    pstate[p] = PS_TERM;
    m |= wake_waiters(EV_EXITED, p);
    return st;
  endfunction

  function automatic rsp_t serve_request(req_t r);
    rsp_t o;
    bit   have_cur;
    int   tgt;
    o = '0;
    tgt = r.target_pid;
    have_cur = valid_pid(cur_pid);
    case (op_t'(r.req_type))
      OP_SCHED: o.status = pick_next();
      OP_SETPRI: begin
        if (valid_pid(tgt) && (pstate[tgt] == PS_READY || pstate[tgt] == PS_RUN))
          enqueue_at(tgt, r.priority_level);
      end
      OP_BLOCK: begin
        if (!have_cur) o.status = ST_NO_CUR;
        else begin
          wkind[cur_pid] = r.event_kind;
          wsrc[cur_pid] = r.event_pid;
          pstate[cur_pid] = PS_BLOCKED;
          drop_from_rings(cur_pid);
          o.woken_mask = wake_waiters(EV_BLOCKED, cur_pid);
          o.status = pick_next();
          o.result_pid = r.event_pid;
        end
      end
      OP_EMIT: o.woken_mask = wake_waiters(r.event_kind, r.event_pid);
      OP_EXIT: begin
        if (!have_cur) o.status = ST_NO_CUR;
        else o.status = retire_running(o.woken_mask);
      end
      OP_KILL: begin
        if (valid_pid(tgt) && pstate[tgt] != PS_FREE && pstate[tgt] != PS_TERM) begin
          if (have_cur && tgt == cur_pid) o.status = retire_running(o.woken_mask);
          else begin
            drop_from_rings(tgt);
            pstate[tgt] = PS_TERM;
            o.status = pick_next();
            o.woken_mask = wake_waiters(EV_EXITED, tgt);
          end
        end
      end
      OP_FORK: begin
        if (!have_cur) o.status = ST_NO_CUR;
        else if (!valid_pid(fresh_pid)) o.status = ST_TAB_FULL;
        else begin
          pstate[fresh_pid] = PS_READY;
          wkind[fresh_pid] = wkind[cur_pid];
          wsrc[fresh_pid] = wsrc[cur_pid];
          enqueue_at(fresh_pid, LVL_LOW);
          o.woken_mask = wake_waiters(EV_CREATED, fresh_pid);
          o.result_pid = pid_t'(fresh_pid);
          fresh_pid++;
        end
      end
      default: ;
    endcase
    o.running_pid = pid_t'(cur_pid);
    return o;
  endfunction

  assign outstanding = expected_rsp.size();

  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      foreach (pstate[i]) begin
        pstate[i] <= PS_FREE;
        wkind[i] <= '0;
        wsrc[i] <= '0;
      end
      pstate[1] <= PS_RUN;
      hiq = {};
      loq = {pid_t'(1)};
      cur_pid = 1;
      fresh_pid = 2;
      errors <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_rsp.size() == 0) begin
          $error("result item with no request outstanding: %h", rsp);
          errors <= errors + 1;
        end else begin
          e = expected_rsp.pop_front();
          if (rsp !== e) begin
            if (rsp.running_pid !== e.running_pid)
              $error("running_pid expected %0d actual %0d", e.running_pid, rsp.running_pid);
            if (rsp.result_pid !== e.result_pid)
              $error("result_pid expected %0d actual %0d", e.result_pid, rsp.result_pid);
            if (rsp.status !== e.status)
              $error("status expected %0d actual %0d", e.status, rsp.status);
            if (rsp.woken_mask !== e.woken_mask)
              $error("woken_mask expected %h actual %h", e.woken_mask, rsp.woken_mask);
            errors <= errors + 1;
          end
        end
      end
      if (push && !full) expected_rsp.push_back(serve_request(req));
    end
  end
endmodule

// ----- tb/tb_two_level_round_robin_scheduler.sv -----
// Testbench top for the two-level round-robin scheduler: stimulus, watchdog and verdict.
module tb_two_level_round_robin_scheduler
  import trrs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  req_t req = '0;
  logic empty;
  logic pop = 1'b0;
  rsp_t rsp;
  int   errors;
  int   outstanding;
  bit   steady = 0;
  int   idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  two_level_round_robin_scheduler i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .empty(empty), .pop(pop), .rsp(rsp)
  );

  trrs_checker i_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .empty(empty), .pop(pop), .rsp(rsp), .errors(errors), .outstanding(outstanding)
  );

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= steady || ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic issue(op_t op, int tgt, logic lvl, int kind, int src);
    req_t r;
    r.req_type = op;
    r.target_pid = 4'(tgt);
    r.priority_level = lvl;
    r.event_kind = 3'(kind);
    r.event_pid = 4'(src);
    while (!steady && $urandom_range(99) < 31) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req <= r;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  function automatic op_t random_op();
    int w;
    w = $urandom_range(99);
    if (w < 22) return OP_SCHED;
    if (w < 38) return OP_SETPRI;
    if (w < 52) return OP_BLOCK;
    if (w < 78) return OP_EMIT;
    if (w < 83) return OP_EXIT;
    if (w < 88) return OP_KILL;
    if (w < 91) return OP_FORK;
    if (w < 94) return OP_NOP;
    return OP_SCHED;
  endfunction

  initial begin
    op_t op;
    int  kind;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    issue(OP_SCHED, 0, LVL_HIGH, 0, 0);
    issue(OP_EXIT, 0, LVL_HIGH, 0, 0);
    issue(OP_FORK, 0, LVL_HIGH, 0, 0);
    issue(OP_FORK, 0, LVL_HIGH, 0, 0);
    issue(OP_FORK, 15, LVL_LOW, 7, 15);
    issue(OP_SETPRI, 2, LVL_HIGH, 0, 0);
    issue(OP_SETPRI, 15, LVL_HIGH, 7, 15);
    issue(OP_SETPRI, 0, LVL_LOW, 0, 0);
    issue(OP_SCHED, 0, LVL_HIGH, 0, 0);
    issue(OP_BLOCK, 0, LVL_HIGH, EV_EXITED, 3);
    issue(OP_BLOCK, 0, LVL_LOW, EV_BLOCKED, 1);
    issue(OP_EMIT, 0, LVL_HIGH, 7, 15);
    issue(OP_KILL, 0, LVL_HIGH, 0, 0);
    issue(OP_KILL, 15, LVL_HIGH, 0, 0);
    issue(OP_KILL, 3, LVL_HIGH, 0, 0);
    issue(OP_EMIT, 0, LVL_HIGH, EV_BLOCKED, 2);
    issue(OP_NOP, 15, LVL_LOW, 7, 15);
    issue(OP_SCHED, 0, LVL_HIGH, 0, 0);
    issue(OP_SETPRI, 4, LVL_LOW, 0, 0);
    issue(OP_KILL, 1, LVL_HIGH, 0, 0);
    issue(OP_EXIT, 0, LVL_HIGH, 0, 0);
    for (int n = 0; n < 1900; n++) begin
      steady = (n >= 700 && n < 1000);
      op = random_op();
      kind = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(2);
      issue(op, $urandom_range(15), 1'($urandom_range(1)), kind,
            ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(1, 8));
    end
    push <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
